// ===== design/base64_stream_encoder_defines.svh =====
// assertion macros for the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent and consequent in the same cycle
`define B64E_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent in the cycle after the antecedent
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define B64E_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/b64e_pkg.sv =====
`default_nettype none

package b64e_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_URL_ALPHABET = 2'd0,
        CFG_NO_PADDING   = 2'd1,
        CFG_LINE_LENGTH  = 2'd2
    } t_cfg_idx;

    localparam logic [7:0] LINE_LENGTH_RESET = 8'd72;
    localparam logic [8:0] LINE_POS_MAX      = 9'd511;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_DIGIT = 8'h30;

    // what a queued group asks of the back end
    typedef enum logic [1:0] {
        KIND_FULL   = 2'd0,
        KIND_CLOSE1 = 2'd1,
        KIND_CLOSE2 = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_job;

    function automatic logic [7:0] f_symbol(input logic [5:0] idx, input logic url);
        logic [7:0] c;
        c = 8'h00;
        if (idx < 6'd26) begin
            c = CHAR_UPPER + {2'b00, idx};
        end else if (idx < 6'd52) begin
            c = CHAR_LOWER + {2'b00, idx} - 8'd26;
        end else if (idx < 6'd62) begin
            c = CHAR_DIGIT + {2'b00, idx} - 8'd52;
        end else if (idx == 6'd62) begin
            c = url ? CHAR_MINUS : CHAR_PLUS;
        end else begin
            c = url ? CHAR_UNDER : CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/b64e_front.sv =====
`default_nettype none

module b64e_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_cmd,
    input  wire logic [7:0]     i_byte,
    output logic                o_ready,
    output logic                o_push,
    output b64e_pkg::t_job      o_job,
    input  wire logic           i_q_ready
);

    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;
    logic [1:0] r_gcnt,  n_gcnt;
    logic       w_accept;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;

    always_comb begin
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_gcnt  = r_gcnt;
        o_push  = 1'b0;
        o_job   = '{kind: b64e_pkg::KIND_FULL, b0: r_held0, b1: r_held1, b2: i_byte};
        if (w_accept) begin
            if (!i_cmd) begin
                if (r_gcnt == 2'd2) begin
                    o_push = 1'b1;
                    n_gcnt = 2'd0;
                end else begin
                    if (r_gcnt[0]) begin
                        n_held1 = i_byte;
                    end else begin
                        n_held0 = i_byte;
                    end
                    n_gcnt = r_gcnt + 2'd1;
                end
            end else begin
                // close: missing bytes of the group count as zero
                o_job.b2 = 8'h00;
                if (r_gcnt == 2'd1) begin
                    o_push      = 1'b1;
                    o_job.kind  = b64e_pkg::KIND_CLOSE1;
                    o_job.b1    = 8'h00;
                end else if (r_gcnt == 2'd2) begin
                    o_push      = 1'b1;
                    o_job.kind  = b64e_pkg::KIND_CLOSE2;
                end
                n_gcnt = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcnt  <= 2'd0;
            r_held0 <= 8'h00;
            r_held1 <= 8'h00;
        end else begin
            r_gcnt  <= n_gcnt;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
    end

endmodule

`default_nettype wire

// ===== design/b64e_fifo.sv =====
`default_nettype none

module b64e_fifo #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/b64e_back.sv =====
`default_nettype none

module b64e_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_url,
    input  wire logic           i_no_pad,
    input  wire logic [7:0]     i_line_len,
    input  wire logic           i_q_valid,
    input  wire b64e_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    output logic [7:0]          o_char,
    output logic                o_last,
    input  wire logic           i_ready
);

    b64e_pkg::t_job r_job;
    logic           r_busy, n_busy;
    logic [2:0]     r_idx, n_idx;
    logic [2:0]     r_last_idx, n_last_idx;
    logic [8:0]     r_line_pos, n_line_pos;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_out_char;
    logic           r_out_last;

    logic           w_out_free;
    logic           w_emit;
    logic           w_emit_last;
    logic           w_load;
    logic [9:0]     w_pos_sum;
    logic [8:0]     w_pos_sat;
    logic           w_wrap;
    logic [5:0]     w_sext;
    logic [2:0]     w_nsym;
    logic [7:0]     w_char;

    assign w_out_free  = !r_out_valid || i_ready;
    assign w_emit      = r_busy && w_out_free;
    assign w_emit_last = w_emit && (r_idx == r_last_idx);
    assign w_load      = i_q_valid && (!r_busy || w_emit_last);
    assign o_pop       = w_load;

    // line position advances by four per full group, saturating
    assign w_pos_sum = {1'b0, r_line_pos} + 10'd4;
    assign w_pos_sat = w_pos_sum[9] ? b64e_pkg::LINE_POS_MAX : w_pos_sum[8:0];
    assign w_wrap    = (i_line_len != 8'd0) && (w_pos_sat >= {1'b0, i_line_len});

    always_comb begin
        case (r_idx[1:0])
            2'd0:    w_sext = r_job.b0[7:2];
            2'd1:    w_sext = {r_job.b0[1:0], r_job.b1[7:4]};
            2'd2:    w_sext = {r_job.b1[3:0], r_job.b2[7:6]};
            default: w_sext = r_job.b2[5:0];
        endcase
        case (r_job.kind)
            b64e_pkg::KIND_CLOSE1: w_nsym = 3'd2;
            b64e_pkg::KIND_CLOSE2: w_nsym = 3'd3;
            default:               w_nsym = 3'd4;
        endcase
        if (r_idx == 3'd4) begin
            w_char = b64e_pkg::CHAR_CR;
        end else if (r_idx == 3'd5) begin
            w_char = b64e_pkg::CHAR_LF;
        end else if (r_idx < w_nsym) begin
            w_char = b64e_pkg::f_symbol(w_sext, i_url);
        end else begin
            w_char = b64e_pkg::CHAR_EQ;
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_last_idx  = r_last_idx;
        n_line_pos  = r_line_pos;
        n_out_valid = r_out_valid;
        if (i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx + 3'd1;
            if (w_emit_last) begin
                n_busy = 1'b0;
            end
        end
        if (w_load) begin
            n_busy = 1'b1;
            n_idx  = 3'd0;
            case (i_job.kind)
                b64e_pkg::KIND_FULL: begin
                    n_last_idx = w_wrap ? 3'd5 : 3'd3;
                    n_line_pos = w_wrap ? 9'd0 : w_pos_sat;
                end
                b64e_pkg::KIND_CLOSE1: n_last_idx = i_no_pad ? 3'd1 : 3'd3;
                b64e_pkg::KIND_CLOSE2: n_last_idx = i_no_pad ? 3'd2 : 3'd3;
                default:               n_last_idx = 3'd3;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 3'd0;
            r_last_idx  <= 3'd0;
            r_line_pos  <= 9'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_last_idx  <= n_last_idx;
            r_line_pos  <= n_line_pos;
            r_out_valid <= n_out_valid;
        end
        if (w_load) begin
            r_job <= i_job;
        end
        if (w_emit) begin
            r_out_char <= w_char;
            r_out_last <= (r_idx == r_last_idx);
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

// ===== design/base64_stream_encoder.sv =====
// base64 stream encoder with optional line wrapping
//
// input stream: one word per byte; tuser = 0 carries a data byte in tdata,
// tuser = 1 is a close that flushes a partial group (tdata ignored)
// output stream: one ascii character per word; tlast marks the final
// character caused by one input word
// every third byte gives four characters, plus cr lf when the line count
// reaches line_length; a close after one or two bytes gives two or three
// characters plus '=' padding unless no_padding is set
// throughput: one character per cycle while the receiver is ready, set by the
// single output register of the emitter; bytes enter at one per cycle while
// the group queue has room
// config: index 0 url_alphabet, 1 no_padding, 2 line_length (0 = no wrap);
// written by the user only while the block is idle, a rule the block leaves unchecked; always ready
// reset: synchronous active low, empties the queue and clears held bytes and
// the line count; line_length returns to 72
// a stalled receiver holds the output word, then the emitter, then the
// queue fills and s_axis_tready drops
`default_nettype none

`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input stream
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic       i_s_axis_tuser,   // [0] cmd: 0 data, 1 close
    // output stream
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_char
    output logic            o_m_axis_tlast,
    // configuration writes
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    // configuration registers
    logic       r_url;
    logic       r_no_pad;
    logic [7:0] r_line_len;

    b64e_pkg::t_job w_push_job;
    b64e_pkg::t_job w_q_job;
    logic           w_push;
    logic           w_pop;
    logic           w_q_ready;
    logic           w_q_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url      <= 1'b0;
            r_no_pad   <= 1'b0;
            r_line_len <= b64e_pkg::LINE_LENGTH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                b64e_pkg::CFG_URL_ALPHABET: r_url      <= i_cfg_data[0];
                b64e_pkg::CFG_NO_PADDING:   r_no_pad   <= i_cfg_data[0];
                b64e_pkg::CFG_LINE_LENGTH:  r_line_len <= i_cfg_data;
                default:                    ;
            endcase
        end
    end

    // front: gathers bytes into groups, queues full groups and flushes
    b64e_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_cmd     (i_s_axis_tuser),
        .i_byte    (i_s_axis_tdata),
        .o_ready   (o_s_axis_tready),
        .o_push    (w_push),
        .o_job     (w_push_job),
        .i_q_ready (w_q_ready)
    );

    // short group queue between front and emitter
    b64e_fifo #(
        .WIDTH ($bits(b64e_pkg::t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_job)
    );

    // back: emits characters, tracks the line, inserts cr lf and padding
    b64e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_url      (r_url),
        .i_no_pad   (r_no_pad),
        .i_line_len (r_line_len),
        .i_q_valid  (w_q_valid),
        .i_job      (w_q_job),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .o_char     (o_m_axis_tdata),
        .o_last     (o_m_axis_tlast),
        .i_ready    (i_m_axis_tready)
    );

    // a group is only queued when the queue has room
    `B64E_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, w_push, w_q_ready)
    // the emitter only takes a group that is there
    `B64E_ASSERT_IMPLY(a_pop_valid, i_clk, i_rst_n, w_pop, w_q_valid)
    // a queued group is visible to the emitter on the next cycle
    `B64E_ASSERT_NEXT(a_push_seen, i_clk, i_rst_n, w_push, w_q_valid)

endmodule

`default_nettype wire

// ===== tb/base64_stream_encoder_tb.sv =====
`default_nettype none

module base64_stream_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // input word kinds carried on tuser
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    // cycles to let a held byte settle before a register write, and the
    // watchdog limit on cycles without any handshake
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 2000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    // tracks encoder state and the characters still owed by the block
    class enc_scoreboard;
        logic       url_sel  = 1'b0;
        logic       pad_off  = 1'b0;
        logic [7:0] line_len = b64e_pkg::LINE_LENGTH_RESET;
        logic [7:0] held [2] = '{8'h00, 8'h00};
        logic [1:0] held_cnt = 2'd0;
        logic [8:0] line_pos = 9'd0;
        t_enc_char  owed [$];
        int         mismatches = 0;

        function void set_reg(b64e_pkg::t_cfg_idx idx, logic [7:0] value);
            case (idx)
                b64e_pkg::CFG_URL_ALPHABET: url_sel  = value[0];
                b64e_pkg::CFG_NO_PADDING:   pad_off  = value[0];
                b64e_pkg::CFG_LINE_LENGTH:  line_len = value;
                default: ;
            endcase
        endfunction

        function logic [7:0] glyph(logic [5:0] idx);
            string abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            logic [7:0] g;
            g = abc[idx];
            if (url_sel && idx == 6'd62) g = b64e_pkg::CHAR_MINUS;
            if (url_sel && idx == 6'd63) g = b64e_pkg::CHAR_UNDER;
            return g;
        endfunction

        function void note_input(logic cmd, logic [7:0] b);
            logic [7:0] chars [$];
            logic [7:0] b0;
            logic [7:0] b1;
            b0 = held[0];
            b1 = held[1];
            if (cmd == CMD_DATA) begin
                if (held_cnt < 2'd2) begin
                    held[held_cnt[0]] = b;
                    held_cnt++;
                    return;
                end
                chars.push_back(glyph(b0[7:2]));
                chars.push_back(glyph({b0[1:0], b1[7:4]}));
                chars.push_back(glyph({b1[3:0], b[7:6]}));
                chars.push_back(glyph(b[5:0]));
                // position saturates while wrapping is off
                line_pos = (line_pos > 9'd507) ? b64e_pkg::LINE_POS_MAX : line_pos + 9'd4;
                if (line_len != 8'd0 && line_pos >= {1'b0, line_len}) begin
                    chars.push_back(b64e_pkg::CHAR_CR);
                    chars.push_back(b64e_pkg::CHAR_LF);
                    line_pos = 9'd0;
                end
            end else if (held_cnt == 2'd1) begin
                chars.push_back(glyph(b0[7:2]));
                chars.push_back(glyph({b0[1:0], 4'b0000}));
                if (!pad_off) begin
                    chars.push_back(b64e_pkg::CHAR_EQ);
                    chars.push_back(b64e_pkg::CHAR_EQ);
                end
            end else if (held_cnt == 2'd2) begin
                chars.push_back(glyph(b0[7:2]));
                chars.push_back(glyph({b0[1:0], b1[7:4]}));
                chars.push_back(glyph({b1[3:0], 2'b00}));
                if (!pad_off) chars.push_back(b64e_pkg::CHAR_EQ);
            end
            held_cnt = 2'd0;
            foreach (chars[i]) owed.push_back('{chars[i], i == chars.size() - 1});
        endfunction

        function void check_result(logic [7:0] ch, logic last);
            t_enc_char want;
            if (owed.size() == 0) begin
                $error("out_char %h (last %b) with nothing expected", ch, last);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (ch !== want.ch) begin
                $error("out_char: expected %h, got %h", want.ch, ch);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last: expected %b, got %b", want.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'h00;
    logic               s_tuser   = CMD_DATA;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [7:0]         m_tdata;
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    b64e_pkg::t_cfg_idx cfg_index = b64e_pkg::CFG_URL_ALPHABET;
    logic [7:0]         cfg_data  = 8'h00;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    enc_scoreboard sb = new;

    base64_stream_encoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] data_byte
        .i_s_axis_tuser  (s_tuser),    // [0] cmd
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [7:0] out_char
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // handshake monitor, receiver stalls and the watchdog share one edge
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        end
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("base64_stream_encoder_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function void set_idling(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default:   begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
    endfunction

    // one input word; valid is left high after the accepting edge so that
    // back-to-back words need no extra assignment
    task automatic send_word(input logic cmd, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic write_reg(input b64e_pkg::t_cfg_idx idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold the sender until every owed character has come out, then give a
    // held byte time to reach the group register
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_triple(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        send_word(CMD_DATA, a);
        send_word(CMD_DATA, b);
        send_word(CMD_DATA, c);
    endtask

    // random words; a long run keeps closes out so the line count saturates
    task automatic run_random(input int n_words, input bit bytes_only);
        for (int i = 0; i < n_words; i++) begin
            if (!bytes_only && $urandom_range(0, 7) == 0) begin
                send_word(CMD_CLOSE, 8'($urandom_range(0, 255)));
            end else begin
                send_word(CMD_DATA, 8'($urandom_range(0, 255)));
            end
        end
        // leaving a partial group open tests a register change mid-group
        if ($urandom_range(0, 1) == 1) send_word(CMD_CLOSE, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [7:0] wrap_len;
        set_idling(IDLE_NONE);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: standard alphabet, padding, wrap at 72
        send_word(CMD_CLOSE, 8'hFF);             // close with nothing held
        send_triple(8'h00, 8'h00, 8'h00);
        send_triple(8'hFF, 8'hFF, 8'hFF);
        send_triple(8'hFB, 8'hEF, 8'hBE);        // every index 62
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_CLOSE, 8'h00);             // one byte, two pads
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_CLOSE, 8'h00);             // two bytes, one pad
        settle();

        // url alphabet, no padding, a break after every group
        write_reg(b64e_pkg::CFG_URL_ALPHABET, 8'd1);
        write_reg(b64e_pkg::CFG_NO_PADDING, 8'd1);
        write_reg(b64e_pkg::CFG_LINE_LENGTH, 8'd4);
        send_triple(8'hFB, 8'hEF, 8'hBE);
        send_triple(8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_CLOSE, 8'h00);
        send_word(CMD_DATA, 8'hA5);
        send_word(CMD_DATA, 8'h5A);
        send_word(CMD_CLOSE, 8'h00);

        for (int p = 0; p < 8; p++) begin
            settle();
            case (p)
                0:       wrap_len = b64e_pkg::LINE_LENGTH_RESET;
                1:       wrap_len = 8'd1;
                2:       wrap_len = 8'd0;        // wrap off, count runs to its limit
                3:       wrap_len = 8'd255;      // saturated count wraps on first group
                5:       wrap_len = 8'd4;
                6:       wrap_len = 8'd76;
                default: wrap_len = 8'($urandom_range(2, 254));
            endcase
            write_reg(b64e_pkg::CFG_URL_ALPHABET, 8'($urandom_range(0, 1)));
            write_reg(b64e_pkg::CFG_NO_PADDING, 8'($urandom_range(0, 1)));
            write_reg(b64e_pkg::CFG_LINE_LENGTH, wrap_len);
            set_idling(t_idle_mode'(p % 4));
            run_random((p == 2) ? 390 : 5, p == 2);
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("base64_stream_encoder_tb passed");
        end else begin
            $display("base64_stream_encoder_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
